### src/rrbs_pkg.sv
// Shared codes, widths and controller/datapath signal groups for the receive ring buffer.
package rrbs_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int OP_W      = 2;
	localparam int BYTE_W    = 8;
	localparam int CNT_W     = 7;
	localparam int POS_W     = 6;
	localparam int STAT_W    = 3;

	// most bytes one read-until may remove
	localparam logic [CNT_W-1:0] MAX_RUN = 7'd64;

	localparam logic [OP_W-1:0] OP_PUSH       = 2'd0;
	localparam logic [OP_W-1:0] OP_POP        = 2'd1;
	localparam logic [OP_W-1:0] OP_READ_UNTIL = 2'd2;
	localparam logic [OP_W-1:0] OP_INDEX_OF   = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL       = 3'd3;
	localparam logic [STAT_W-1:0] ST_ZERO_COUNT = 3'd4;

	typedef struct packed {
		logic              load;        // capture the request, start scan at head
		logic              write;       // store pushed byte, advance write pointer
		logic              emit;        // present one result
		logic [STAT_W-1:0] emit_status;
		logic              emit_byte;   // result data is the byte just read
		logic              emit_pos;    // result position is the scan offset
		logic              emit_last;
		logic              step;        // advance scan pointer and offset
		logic              head_adv;    // head moves past the byte just read
	} rrbs_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            empty;
		logic            full;
		logic            cnt_zero;
		logic            match;       // byte just read equals request byte
		logic            at_end;      // next scan cell is the write pointer
		logic            count_done;  // this result reaches the count
	} rrbs_stat_t;

endpackage

### src/rrbs_dp.sv
// Datapath: byte store, pointers, scan counter and result registers.
module rrbs_dp #(
	parameter int DEPTH = rrbs_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rrbs_pkg::OP_W-1:0]     operation,
	input  logic [rrbs_pkg::BYTE_W-1:0]   byte_value,
	input  logic [rrbs_pkg::CNT_W-1:0]    max_count,
	input  rrbs_pkg::rrbs_cmd_t           cmd,
	output rrbs_pkg::rrbs_stat_t          stat,
	output logic                          strobe,
	output logic [rrbs_pkg::BYTE_W-1:0]   data,
	output logic [rrbs_pkg::POS_W-1:0]    position,
	output logic [rrbs_pkg::STAT_W-1:0]   status,
	output logic                          last
);
	import rrbs_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH - 1);

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		return (p == PTR_TOP) ? '0 : p + 1'b1;
	endfunction

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;
	logic [PTR_W-1:0]  rd_ptr_q, wr_ptr_q, scan_q;
	logic [PTR_W-1:0]  scan_nxt, rd_addr;
	logic [OP_W-1:0]   op_q;
	logic [BYTE_W-1:0] val_q;
	logic [CNT_W-1:0]  cnt_q, k_q;
	logic              strobe_q, last_q;
	logic [BYTE_W-1:0] data_q;
	logic [POS_W-1:0]  position_q;
	logic [STAT_W-1:0] status_q;

	assign scan_nxt = advance(scan_q);
	// read ahead so the next byte is ready in the cycle after a step
	assign rd_addr  = cmd.step ? scan_nxt : scan_q;

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[wr_ptr_q] <= val_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.write) begin
				wr_ptr_q <= advance(wr_ptr_q);
			end
			if (cmd.head_adv) begin
				rd_ptr_q <= scan_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			val_q  <= byte_value;
			cnt_q  <= (max_count > MAX_RUN) ? MAX_RUN : max_count;
			scan_q <= rd_ptr_q;
			k_q    <= '0;
		end else if (cmd.step) begin
			scan_q <= scan_nxt;
			k_q    <= k_q + 1'b1;
		end
		if (cmd.emit) begin
			data_q     <= cmd.emit_byte ? rd_data_q : '0;
			position_q <= cmd.emit_pos ? k_q[POS_W-1:0] : '0;
			status_q   <= cmd.emit_status;
			last_q     <= cmd.emit_last;
		end
	end

	always_comb begin
		stat.op         = op_q;
		stat.empty      = (rd_ptr_q == wr_ptr_q);
		stat.full       = (advance(wr_ptr_q) == rd_ptr_q);
		stat.cnt_zero   = (cnt_q == '0);
		stat.match      = (rd_data_q == val_q);
		stat.at_end     = (scan_nxt == wr_ptr_q);
		stat.count_done = ((k_q + 1'b1) >= cnt_q);
	end

	assign strobe   = strobe_q;
	assign data     = data_q;
	assign position = position_q;
	assign status   = status_q;
	assign last     = last_q;

endmodule

### src/rrbs_ctrl.sv
// Controller state machine sequencing each operation over the datapath.
module rrbs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  rrbs_pkg::rrbs_stat_t stat,
	output rrbs_pkg::rrbs_cmd_t  cmd
);
	import rrbs_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECIDE = 2'd1;
	localparam logic [1:0] S_STEP   = 2'd2;

	logic [1:0] state_q, state_nxt;
	logic       stop;

	assign busy = (state_q != S_IDLE);
	assign stop = stat.at_end || stat.match || stat.count_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_nxt = S_IDLE;
				case (stat.op)
					OP_PUSH: begin
						cmd.emit        = 1'b1;
						cmd.emit_last   = 1'b1;
						cmd.emit_status = stat.full ? ST_FULL : ST_OK;
						cmd.write       = !stat.full;
					end
					OP_POP: begin
						if (stat.empty) begin
							cmd.emit        = 1'b1;
							cmd.emit_last   = 1'b1;
							cmd.emit_status = ST_EMPTY;
						end else begin
							state_nxt = S_STEP;
						end
					end
					OP_READ_UNTIL: begin
						if (stat.cnt_zero) begin
							cmd.emit        = 1'b1;
							cmd.emit_last   = 1'b1;
							cmd.emit_status = ST_ZERO_COUNT;
						end else if (stat.empty) begin
							cmd.emit        = 1'b1;
							cmd.emit_last   = 1'b1;
							cmd.emit_status = ST_EMPTY;
						end else begin
							state_nxt = S_STEP;
						end
					end
					default: begin
						if (stat.empty) begin
							cmd.emit        = 1'b1;
							cmd.emit_last   = 1'b1;
							cmd.emit_status = ST_NOT_FOUND;
						end else begin
							state_nxt = S_STEP;
						end
					end
				endcase
			end
			S_STEP: begin
				state_nxt = S_IDLE;
				case (stat.op)
					OP_POP: begin
						cmd.emit        = 1'b1;
						cmd.emit_last   = 1'b1;
						cmd.emit_byte   = 1'b1;
						cmd.emit_status = ST_OK;
						cmd.head_adv    = 1'b1;
					end
					OP_READ_UNTIL: begin
						cmd.emit        = 1'b1;
						cmd.emit_last   = stop;
						cmd.emit_byte   = 1'b1;
						cmd.emit_status = ST_OK;
						cmd.head_adv    = 1'b1;
						cmd.step        = !stop;
						if (!stop) begin
							state_nxt = S_STEP;
						end
					end
					OP_INDEX_OF: begin
						if (stat.match) begin
							cmd.emit        = 1'b1;
							cmd.emit_last   = 1'b1;
							cmd.emit_pos    = 1'b1;
							cmd.emit_status = ST_OK;
						end else if (stat.at_end) begin
							cmd.emit        = 1'b1;
							cmd.emit_last   = 1'b1;
							cmd.emit_status = ST_NOT_FOUND;
						end else begin
							cmd.step  = 1'b1;
							state_nxt = S_STEP;
						end
					end
					default: begin
						state_nxt = S_IDLE;
					end
				endcase
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

### src/receive_ring_buffer_with_search.sv
// Receive byte ring buffer with pop, read-until-delimiter and byte search.
// Push is answered from the decide state; pop, and the first byte of a read-until
// or a search, from the step state after it, once the store's read port has the byte.
// Throughput: read-until then gives one byte per cycle; index-of checks one byte per
// cycle through the single store read port.
// Reset clears both pointers (buffer empty) and the controller; the receiver cannot stall.
module receive_ring_buffer_with_search #(
	parameter int DEPTH = rrbs_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rrbs_pkg::OP_W-1:0]     operation,
	input  logic [rrbs_pkg::BYTE_W-1:0]   byte_value,
	input  logic [rrbs_pkg::CNT_W-1:0]    max_count,
	output logic                          strobe,
	output logic [rrbs_pkg::BYTE_W-1:0]   data,
	output logic [rrbs_pkg::POS_W-1:0]    position,
	output logic [rrbs_pkg::STAT_W-1:0]   status,
	output logic                          last
);
	import rrbs_pkg::*;

	// Command and status groups between sequencer and datapath
	rrbs_cmd_t  cmd;
	rrbs_stat_t stat;

	// Sequencer: one request at a time; busy stays high until its final result
	// has been registered, so a new transfer is taken the cycle that result shows.
	rrbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Datapath: the ring store, head and tail pointers, the scan pointer that
	// walks from the head, and the result registers driven onto the ports.
	rrbs_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.operation  (operation),
		.byte_value (byte_value),
		.max_count  (max_count),
		.cmd        (cmd),
		.stat       (stat),
		.strobe     (strobe),
		.data       (data),
		.position   (position),
		.status     (status),
		.last       (last)
	);

endmodule
